[hdl/rims_pkg.sv]
// Package for the RGB indicator mode sequencer: modes, opcodes, command record,
// fixed system event commands and the pin byte encoder.
// No dependencies.
`default_nettype none

package rims_pkg;

  typedef enum logic [1:0] {
    MODE_STATIC = 2'd0,
    MODE_BLINK  = 2'd1,
    MODE_PULSE  = 2'd2,
    MODE_OFF    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_CMD     = 2'd1,
    OP_EVENT   = 2'd2,
    OP_RELEASE = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    EV_NO_CREDS     = 2'd0,
    EV_CONNECTED    = 2'd1,
    EV_DISCONNECTED = 2'd2,
    EV_HEALTH_ALERT = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    CFG_RED_BIT      = 2'd0,
    CFG_GREEN_BIT    = 2'd1,
    CFG_BLUE_BIT     = 2'd2,
    CFG_COMMON_ANODE = 2'd3
  } cfg_idx_e;

  localparam logic [7:0] LitThreshold    = 8'd127;
  localparam logic [7:0] FullLevel       = 8'd255;
  localparam logic [2:0] GreenFlashLimit = 3'd6;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [31:0] period;
    logic        manual;
  } cmd_t;

  typedef struct packed {
    logic [2:0] red_bit;
    logic [2:0] green_bit;
    logic [2:0] blue_bit;
    logic       common_anode;
  } cfg_t;

  // Fixed command behind each system event; never manual.
  function automatic cmd_t event_cmd(input event_e id);
    cmd_t c;
    unique case (id)
      EV_NO_CREDS:     c = '{MODE_PULSE,  8'd255, 8'd162, 8'd0, 32'd3000, 1'b0};
      EV_CONNECTED:    c = '{MODE_BLINK,  8'd0,   8'd255, 8'd0, 32'd300,  1'b0};
      EV_DISCONNECTED: c = '{MODE_STATIC, 8'd255, 8'd0,   8'd0, 32'd0,    1'b0};
      EV_HEALTH_ALERT: c = '{MODE_BLINK,  8'd255, 8'd0,   8'd0, 32'd150,  1'b0};
      default:         c = '{MODE_OFF,    8'd0,   8'd0,   8'd0, 32'd0,    1'b0};
    endcase
    return c;
  endfunction

  // OR the three channel bits into one byte; polarity follows common anode.
  function automatic logic [7:0] pin_byte(input cfg_t cfg, input logic lit_r,
                                          input logic lit_g, input logic lit_b);
    logic [7:0] v;
    v = 8'd0;
    if (lit_r ^ cfg.common_anode) v = v | (8'd1 << cfg.red_bit);
    if (lit_g ^ cfg.common_anode) v = v | (8'd1 << cfg.green_bit);
    if (lit_b ^ cfg.common_anode) v = v | (8'd1 << cfg.blue_bit);
    return v;
  endfunction

endpackage

`default_nettype wire

[hdl/rgb_indicator_mode_sequencer.sv]
// RGB indicator mode sequencer: input register, one pass of effect logic, result register.
// Depends on rims_pkg.
// A beat held in the input register gives its pin byte (if any) in the result register when the pass fires.
// Throughput: one beat per cycle; the input register frees as the effect pass fires, which
// waits only while a held pin byte is not taken on out_ready_i.
// Reset (async, active low) clears valid flags and all effect state; pin map resets to 0/1/2.
`default_nettype none

module rgb_indicator_mode_sequencer
  import rims_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [2:0]  cfg_wdata_i,
  // input beats
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [1:0]  event_id_i,
  input  wire logic [1:0]  mode_i,
  input  wire logic [7:0]  red_i,
  input  wire logic [7:0]  green_i,
  input  wire logic [7:0]  blue_i,
  input  wire logic [31:0] blink_period_i,
  input  wire logic        manual_i,
  // result beats
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       pin_byte_o
);

  typedef struct packed {
    opcode_e opcode;
    event_e  event_id;
    cmd_t    cmd;
  } in_beat_t;

  // configuration
  cfg_t cfg_q;

  // input register
  logic     in_valid_q;
  in_beat_t in_q;

  // effect state
  cmd_t        active_q, active_d;
  logic        phase_q, phase_d;
  logic [2:0]  toggle_q, toggle_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic        override_q, override_d;
  cmd_t        saved_q, saved_d;

  // result register
  logic       out_valid_q;
  logic [7:0] pin_q;

  logic       out_free;
  logic       fire;
  logic       emit;
  logic [7:0] emit_byte;

  // The result slot is free when empty or being drained this cycle.
  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && out_free;
  // Take a new beat when the input register is empty or the held one moves on.
  assign in_ready_o = !in_valid_q || fire;

  assign out_valid_o = out_valid_q;
  assign pin_byte_o  = pin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{3'd0, 3'd1, 3'd2, 1'b0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RED_BIT:      cfg_q.red_bit      <= cfg_wdata_i;
        CFG_GREEN_BIT:    cfg_q.green_bit    <= cfg_wdata_i;
        CFG_BLUE_BIT:     cfg_q.blue_bit     <= cfg_wdata_i;
        CFG_COMMON_ANODE: cfg_q.common_anode <= cfg_wdata_i[0];
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  // Input register: hold the beat until the effect pass consumes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= '{opcode_e'(opcode_i), event_e'(event_id_i),
                '{mode_e'(mode_i), red_i, green_i, blue_i, blink_period_i, manual_i}};
    end
  end

  // Effect pass: apply a command, event or release, or count a tick, then run one effect step.
  always_comb begin
    cmd_t c;
    logic apply;
    logic run_step;
    c          = in_q.cmd;
    apply      = 1'b0;
    run_step   = 1'b0;
    active_d   = active_q;
    phase_d    = phase_q;
    toggle_d   = toggle_q;
    elapsed_d  = elapsed_q;
    override_d = override_q;
    saved_d    = saved_q;
    emit       = 1'b0;
    emit_byte  = 8'd0;

    unique case (in_q.opcode)
      OP_TICK: begin
        // Saturate instead of wrapping on a very long wait.
        elapsed_d = (elapsed_q == '1) ? elapsed_q : elapsed_q + 32'd1;
        run_step  = 1'b1;
      end
      OP_CMD: begin
        apply = 1'b1;
      end
      OP_EVENT: begin
        // Drop system events while the user holds the override.
        if (!override_q) begin
          c       = event_cmd(in_q.event_id);
          saved_d = c;
          apply   = 1'b1;
        end
      end
      OP_RELEASE: begin
        c     = saved_q;
        apply = 1'b1;
      end
      default: begin
        apply = 1'b0;
      end
    endcase

    if (apply) begin
      active_d   = c;
      override_d = c.manual;
      phase_d    = 1'b1;
      toggle_d   = 3'd0;
      elapsed_d  = 32'd0;
      unique case (c.mode)
        MODE_STATIC: begin
          emit      = 1'b1;
          emit_byte = pin_byte(cfg_q, c.red > LitThreshold, c.green > LitThreshold,
                               c.blue > LitThreshold);
        end
        MODE_OFF: begin
          emit      = 1'b1;
          emit_byte = pin_byte(cfg_q, 1'b0, 1'b0, 1'b0);
        end
        default: run_step = 1'b1;
      endcase
    end

    if (run_step && (active_d.mode == MODE_BLINK || active_d.mode == MODE_PULSE)) begin
      if (active_d.period == 32'd0) begin
        active_d.mode = MODE_OFF;
      end else if (elapsed_d >= (active_d.period >> 1)) begin
        elapsed_d = 32'd0;
        phase_d   = !phase_d;
        emit      = 1'b1;
        if (!active_d.manual && active_d.green == FullLevel) begin
          // Green flash: six toggles of green alone, then go dark.
          if (toggle_d < GreenFlashLimit) begin
            emit_byte = pin_byte(cfg_q, 1'b0, phase_d, 1'b0);
            toggle_d  = toggle_d + 3'd1;
          end else begin
            active_d.mode = MODE_OFF;
            emit_byte     = pin_byte(cfg_q, 1'b0, 1'b0, 1'b0);
          end
        end else if (phase_d) begin
          emit_byte = pin_byte(cfg_q, active_d.red > LitThreshold,
                               active_d.green > LitThreshold, active_d.blue > LitThreshold);
        end else begin
          emit_byte = pin_byte(cfg_q, 1'b0, 1'b0, 1'b0);
        end
      end
    end
  end

  // Effect state advances only when the pass fires.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= '{MODE_OFF, 8'd0, 8'd0, 8'd0, 32'd0, 1'b0};
      phase_q    <= 1'b0;
      toggle_q   <= 3'd0;
      elapsed_q  <= 32'd0;
      override_q <= 1'b0;
      saved_q    <= '{MODE_STATIC, 8'd0, 8'd0, 8'd0, 32'd0, 1'b0};
    end else if (fire) begin
      active_q   <= active_d;
      phase_q    <= phase_d;
      toggle_q   <= toggle_d;
      elapsed_q  <= elapsed_d;
      override_q <= override_d;
      saved_q    <= saved_d;
    end
  end

  // Result register: load on a firing pass, clear once the beat is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      pin_q <= emit_byte;
    end
  end

  // Assertions
  a_toggle_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    toggle_q <= GreenFlashLimit)
    else $error("green flash count ran past its limit");

  a_no_zero_period_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((active_q.mode == MODE_BLINK || active_q.mode == MODE_PULSE) &&
      active_q.period == 32'd0))
    else $error("blink or pulse left active with a zero period");

  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_q.opcode == OP_RELEASE) |=> !override_q)
    else $error("release did not clear the override");

  a_cmd_override: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_q.opcode == OP_CMD) |=> (override_q == $past(in_q.cmd.manual)))
    else $error("override does not follow the command's manual flag");

endmodule

`default_nettype wire

[dv/rgb_indicator_mode_sequencer_test.sv]
// Self-checking testbench for rgb_indicator_mode_sequencer: directed table, then random
// phases under several pin maps; every pin byte is checked against the table or an in-bench predictor.
// Depends on rims_pkg (modes, opcodes, events, register indexes, command and pin-map types).
module rgb_indicator_mode_sequencer_test;
  import rims_pkg::*;

  localparam int HalfPeriod    = 5;
  localparam int ResetCycles   = 7;
  localparam int SettleCycles  = 6;      // pipeline is two deep; leave some slack
  localparam int HoldCycles    = 150;    // long receiver hold-off
  localparam int Phases        = 5;
  localparam int PhaseItems    = 250;
  localparam int TimeoutUnits  = 5_000_000;

  typedef struct packed {
    opcode_e     op;
    event_e      ev;
    mode_e       mode;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [31:0] period;
    logic        manual;
  } beat_t;

  typedef enum bit {ROW_PREDICTED, ROW_TYPED} row_check_e;

  typedef struct packed {
    beat_t      b;
    row_check_e how;
    bit         has_pin;
    logic [7:0] pin;
  } row_t;

  // DUT connections, all known from time zero
  logic        clk_i     = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_idx   = '0;
  logic [2:0]  cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  logic [1:0]  opcode    = '0;
  logic [1:0]  event_id  = '0;
  logic [1:0]  mode      = '0;
  logic [7:0]  red       = '0;
  logic [7:0]  green     = '0;
  logic [7:0]  blue      = '0;
  logic [31:0] blink_period = '0;
  logic        manual    = 1'b0;
  logic        out_ready = 1'b0;
  wire logic   in_ready_o;
  wire logic   out_valid_o;
  wire logic [7:0] pin_byte_o;

  // Predictor state: active effect, lit phase, flash count, ms counter, override, saved command
  cmd_t        live_cmd       = '{MODE_OFF, 8'd0, 8'd0, 8'd0, 32'd0, 1'b0};
  cmd_t        stored_sys_cmd = '{MODE_STATIC, 8'd0, 8'd0, 8'd0, 32'd0, 1'b0};
  logic        lit_phase      = 1'b0;
  logic [2:0]  flash_count    = '0;
  logic [31:0] ms_since       = '0;
  logic        user_hold      = 1'b0;
  cfg_t        pin_map        = '{3'd0, 3'd1, 3'd2, 1'b0};

  logic [7:0]  pin_q [$];       // pin bytes still owed by the block
  row_t        plan [$];        // directed stimulus table
  int          fail_count = 0;
  int          tx_calm = 0;     // remaining beats of a no-gap stretch, sender side
  int          rx_calm = 0;     // same, receiver side
  bit          hold_req = 1'b0; // ask the receiver for one long hold-off

  rgb_indicator_mode_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode),
    .event_id_i    (event_id),
    .mode_i        (mode),
    .red_i         (red),
    .green_i       (green),
    .blue_i        (blue),
    .blink_period_i(blink_period),
    .manual_i      (manual),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .pin_byte_o    (pin_byte_o)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Hold reset low, then release it for good.
  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_n <= 1'b1;
  end

  // Watchdog: end the run if the traffic ever locks up.
  initial begin
    #TimeoutUnits;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Map three intensities onto the pin byte under the current pin map.
  function automatic logic [7:0] to_pins(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    logic [7:0] v;
    v = '0;
    if ((r > LitThreshold) != pin_map.common_anode) v[pin_map.red_bit]   = 1'b1;
    if ((g > LitThreshold) != pin_map.common_anode) v[pin_map.green_bit] = 1'b1;
    if ((b > LitThreshold) != pin_map.common_anode) v[pin_map.blue_bit]  = 1'b1;
    return v;
  endfunction

  function automatic cmd_t sys_cmd(input event_e id);
    case (id)
      EV_NO_CREDS:     return '{MODE_PULSE,  8'd255, 8'd162, 8'd0, 32'd3000, 1'b0};
      EV_CONNECTED:    return '{MODE_BLINK,  8'd0,   8'd255, 8'd0, 32'd300,  1'b0};
      EV_DISCONNECTED: return '{MODE_STATIC, 8'd255, 8'd0,   8'd0, 32'd0,    1'b0};
      default:         return '{MODE_BLINK,  8'd255, 8'd0,   8'd0, 32'd150,  1'b0};
    endcase
  endfunction

  // One effect step for blink and pulse: stop on a zero period, toggle once half a
  // period has passed, and run the six-flash green sequence for non-manual full-green effects.
  function automatic bit advance_effect(output logic [7:0] pins);
    pins = '0;
    if (live_cmd.mode != MODE_BLINK && live_cmd.mode != MODE_PULSE) return 1'b0;
    if (live_cmd.period == '0) begin
      live_cmd.mode = MODE_OFF;
      return 1'b0;
    end
    if (ms_since < (live_cmd.period >> 1)) return 1'b0;
    ms_since  = '0;
    lit_phase = ~lit_phase;
    if (!live_cmd.manual && live_cmd.green == FullLevel) begin
      if (flash_count < GreenFlashLimit) begin
        pins = to_pins(8'd0, lit_phase ? FullLevel : 8'd0, 8'd0);
        flash_count++;
      end else begin
        live_cmd.mode = MODE_OFF;
        pins = to_pins(8'd0, 8'd0, 8'd0);
      end
      return 1'b1;
    end
    pins = lit_phase ? to_pins(live_cmd.red, live_cmd.green, live_cmd.blue)
                     : to_pins(8'd0, 8'd0, 8'd0);
    return 1'b1;
  endfunction

  // Make a command the live effect and restart its timing.
  function automatic bit start_cmd(input cmd_t c, output logic [7:0] pins);
    live_cmd    = c;
    user_hold   = c.manual;
    lit_phase   = 1'b1;
    flash_count = '0;
    ms_since    = '0;
    pins        = '0;
    if (c.mode == MODE_STATIC) begin
      pins = to_pins(c.red, c.green, c.blue);
      return 1'b1;
    end
    if (c.mode == MODE_OFF) begin
      pins = to_pins(8'd0, 8'd0, 8'd0);
      return 1'b1;
    end
    return advance_effect(pins);
  endfunction

  // Advance the predictor by one accepted beat; returns 1 when a pin byte is due.
  function automatic bit predict_beat(input beat_t b, output logic [7:0] pins);
    pins = '0;
    case (b.op)
      OP_TICK: begin
        if (ms_since != '1) ms_since++;
        return advance_effect(pins);
      end
      OP_CMD:
        return start_cmd(cmd_t'{b.mode, b.red, b.green, b.blue, b.period, b.manual}, pins);
      OP_EVENT: begin
        if (user_hold) return 1'b0;
        stored_sys_cmd = sys_cmd(b.ev);
        return start_cmd(stored_sys_cmd, pins);
      end
      default: begin
        user_hold = 1'b0;
        return start_cmd(stored_sys_cmd, pins);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Idle cycles before the next beat; now and then start a run with no idling.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // Fully random beat; unused fields stay random so every bit toggles.
  function automatic beat_t scatter();
    beat_t b;
    b.op     = opcode_e'($urandom_range(0, 3));
    b.ev     = event_e'($urandom_range(0, 3));
    b.mode   = mode_e'($urandom_range(0, 3));
    b.red    = 8'($urandom_range(0, 255));
    b.green  = 8'($urandom_range(0, 255));
    b.blue   = 8'($urandom_range(0, 255));
    b.period = $urandom();
    b.manual = 1'($urandom_range(0, 1));
    return b;
  endfunction

  // Intensity biased toward the lit threshold and the rails.
  function automatic logic [7:0] level();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return LitThreshold;
      2:       return LitThreshold + 8'd1;
      3:       return FullLevel;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Beat that opens a scene: mostly commands, then events, releases and stray ticks.
  function automatic beat_t random_head();
    beat_t b;
    int    pick;
    b    = scatter();
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      b.op    = OP_CMD;
      b.red   = level();
      b.green = ($urandom_range(0, 2) == 0) ? FullLevel : level();
      b.blue  = level();
      pick    = $urandom_range(0, 99);
      if (pick < 70)      b.period = $urandom_range(0, 12);
      else if (pick < 85) b.period = $urandom_range(13, 300);
      else if (pick < 95) b.period = $urandom();
      else                b.period = 32'hFFFF_FFFF - $urandom_range(0, 1);
      b.manual = ($urandom_range(0, 3) == 0);
    end else if (pick < 80) begin
      b.op = OP_EVENT;
    end else if (pick < 95) begin
      b.op = OP_RELEASE;
    end else begin
      b.op = OP_TICK;
    end
    return b;
  endfunction

  // Offer one beat after an optional gap; return at the edge that accepts it.
  task automatic send_beat(input beat_t b, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    opcode       <= b.op;
    event_id     <= b.ev;
    mode         <= b.mode;
    red          <= b.red;
    green        <= b.green;
    blue         <= b.blue;
    blink_period <= b.period;
    manual       <= b.manual;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Send a random beat, predict it and tally it unless the block just drops it.
  task automatic play(input beat_t b, input bit eager, inout int tally);
    logic [7:0] pins;
    if (!(b.op == OP_EVENT && user_hold)) tally++;
    send_beat(b, eager ? 0 : draw_wait(tx_calm));
    if (predict_beat(b, pins)) pin_q.push_back(pins);
  endtask

  // Drop valid, wait for every owed pin byte, then let the pipeline run dry.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pin_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write all four pin-map registers on consecutive edges.
  task automatic load_pin_map(input cfg_t m);
    logic [2:0] val [4];
    cfg_idx_e   slot [4];
    val[0] = m.red_bit;          slot[0] = CFG_RED_BIT;
    val[1] = m.green_bit;        slot[1] = CFG_GREEN_BIT;
    val[2] = m.blue_bit;         slot[2] = CFG_BLUE_BIT;
    val[3] = {2'b00, m.common_anode}; slot[3] = CFG_COMMON_ANODE;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= slot[i];
      cfg_wdata <= val[i];
      @(posedge clk_i);
    end
    cfg_we  <= 1'b0;
    pin_map = m;
  endtask

  task automatic note_failure(input string what, input logic [7:0] want,
                              input logic [7:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("ERROR at %0t: %s: expected %02h, got %02h", $time, what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, one long hold-off on request, and the checker
  // ---------------------------------------------------------------------------

  initial begin : receiver
    int stall;
    while (!rst_n) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HoldCycles;
      end else begin
        stall = draw_wait(rx_calm);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Compare every accepted pin byte with the oldest one owed.
  always @(posedge clk_i) begin : result_check
    logic [7:0] want;
    if (rst_n && out_valid_o && out_ready) begin
      if (pin_q.size() == 0) begin
        note_failure("unexpected pin byte", 8'h00, pin_byte_o);
      end else begin
        want = pin_q.pop_front();
        if (pin_byte_o !== want) note_failure("pin byte mismatch", want, pin_byte_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: directed table, then random phases under changing pin maps
  // ---------------------------------------------------------------------------

  initial begin : sender
    logic [7:0] pins;
    bit         has;
    beat_t      b;
    cfg_t       m;
    int         tally;
    int         run;

    // Directed rows under the reset pin map (red 0, green 1, blue 2, common cathode).
    // Tick straight after reset: effect is off, no beat.
    plan.push_back('{'{OP_TICK, EV_NO_CREDS, MODE_STATIC, 8'd0, 8'd0, 8'd0, 32'd0, 1'b0},
                     ROW_TYPED, 1'b0, 8'h00});
    // Static at full scale, then black under manual with the largest period.
    plan.push_back('{'{OP_CMD, EV_NO_CREDS, MODE_STATIC, 8'd255, 8'd255, 8'd255, 32'd0, 1'b0},
                     ROW_TYPED, 1'b1, 8'h07});
    plan.push_back('{'{OP_CMD, EV_NO_CREDS, MODE_STATIC, 8'd0, 8'd0, 8'd0, 32'hFFFF_FFFF, 1'b1},
                     ROW_TYPED, 1'b1, 8'h00});
    // Threshold: 128 lights, 127 does not.
    plan.push_back('{'{OP_CMD, EV_NO_CREDS, MODE_STATIC, 8'd128, 8'd127, 8'd128, 32'd0, 1'b0},
                     ROW_TYPED, 1'b1, 8'h05});
    plan.push_back('{'{OP_CMD, EV_NO_CREDS, MODE_OFF, 8'd255, 8'd255, 8'd255, 32'd0, 1'b0},
                     ROW_TYPED, 1'b1, 8'h00});
    // Blink with a zero period stops at once.
    plan.push_back('{'{OP_CMD, EV_NO_CREDS, MODE_BLINK, 8'd255, 8'd255, 8'd255, 32'd0, 1'b0},
                     ROW_TYPED, 1'b0, 8'h00});
    // Manual blink, period 4: toggles every second tick.
    plan.push_back('{'{OP_CMD, EV_NO_CREDS, MODE_BLINK, 8'd255, 8'd0, 8'd255, 32'd4, 1'b1},
                     ROW_TYPED, 1'b0, 8'h00});
    repeat (4)
      plan.push_back('{'{OP_TICK, EV_NO_CREDS, MODE_STATIC, 8'd0, 8'd0, 8'd0, 32'd0, 1'b0},
                       ROW_PREDICTED, 1'b0, 8'h00});
    // Event under override is dropped; release replays the saved (reset) command.
    plan.push_back('{'{OP_EVENT, EV_HEALTH_ALERT, MODE_STATIC, 8'd0, 8'd0, 8'd0, 32'd0, 1'b0},
                     ROW_TYPED, 1'b0, 8'h00});
    plan.push_back('{'{OP_RELEASE, EV_NO_CREDS, MODE_STATIC, 8'd0, 8'd0, 8'd0, 32'd0, 1'b0},
                     ROW_TYPED, 1'b1, 8'h00});
    plan.push_back('{'{OP_EVENT, EV_DISCONNECTED, MODE_STATIC, 8'd0, 8'd0, 8'd0, 32'd0, 1'b0},
                     ROW_TYPED, 1'b1, 8'h01});
    plan.push_back('{'{OP_EVENT, EV_HEALTH_ALERT, MODE_STATIC, 8'd0, 8'd0, 8'd0, 32'd0, 1'b0},
                     ROW_TYPED, 1'b0, 8'h00});
    plan.push_back('{'{OP_EVENT, EV_NO_CREDS, MODE_STATIC, 8'd0, 8'd0, 8'd0, 32'd0, 1'b0},
                     ROW_TYPED, 1'b0, 8'h00});
    // Pulse with period 1: half a period is zero, so it toggles on the command itself.
    plan.push_back('{'{OP_CMD, EV_NO_CREDS, MODE_PULSE, 8'd200, 8'd100, 8'd200, 32'd1, 1'b0},
                     ROW_PREDICTED, 1'b0, 8'h00});
    plan.push_back('{'{OP_TICK, EV_NO_CREDS, MODE_STATIC, 8'd0, 8'd0, 8'd0, 32'd0, 1'b0},
                     ROW_PREDICTED, 1'b0, 8'h00});
    // System-style green blink: six green flashes, then off.
    plan.push_back('{'{OP_CMD, EV_NO_CREDS, MODE_BLINK, 8'd0, 8'd255, 8'd0, 32'd2, 1'b0},
                     ROW_PREDICTED, 1'b0, 8'h00});
    repeat (7)
      plan.push_back('{'{OP_TICK, EV_NO_CREDS, MODE_STATIC, 8'd0, 8'd0, 8'd0, 32'd0, 1'b0},
                       ROW_PREDICTED, 1'b0, 8'h00});
    // Manual green at full scale skips the flash rule; release replays the pulse event.
    plan.push_back('{'{OP_CMD, EV_NO_CREDS, MODE_PULSE, 8'd0, 8'd255, 8'd0, 32'hFFFF_FFFF, 1'b1},
                     ROW_PREDICTED, 1'b0, 8'h00});
    plan.push_back('{'{OP_RELEASE, EV_NO_CREDS, MODE_STATIC, 8'd0, 8'd0, 8'd0, 32'd0, 1'b0},
                     ROW_PREDICTED, 1'b0, 8'h00});

    while (!rst_n) @(posedge clk_i);

    // Walk the table; typed rows still advance the predictor.
    foreach (plan[i]) begin
      send_beat(plan[i].b, draw_wait(tx_calm));
      has = predict_beat(plan[i].b, pins);
      if (plan[i].how == ROW_TYPED) begin
        has  = plan[i].has_pin;
        pins = plan[i].pin;
      end
      if (has) pin_q.push_back(pins);
    end

    // Random phases; each starts from an idle block with a fresh pin map.
    for (int p = 0; p < Phases; p++) begin
      drain_and_settle();
      case (p)
        0:       m = '{3'd7, 3'd7, 3'd7, 1'b1};
        1:       m = '{3'd0, 3'd0, 3'd0, 1'b0};
        2:       m = '{3'd5, 3'd6, 3'd7, 1'b1};
        default: m = '{3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                       3'($urandom_range(0, 7)), 1'($urandom_range(0, 1))};
      endcase
      load_pin_map(m);
      tally = 0;

      // Back-pressure: stall the receiver for a long stretch and keep feeding static
      // commands so the pipeline fills and input ready drops.
      if (p == 1) begin
        hold_req = 1'b1;
        repeat (24) begin
          b      = scatter();
          b.op   = OP_CMD;
          b.mode = MODE_STATIC;
          play(b, 1'b1, tally);
        end
      end

      // Scenes: one command-like beat followed by a run of ticks, sometimes long
      // enough to carry the system blink effects through several toggles.
      while (tally < PhaseItems) begin
        play(random_head(), 1'b0, tally);
        run = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 16);
        for (int k = 0; k < run && tally < PhaseItems; k++) begin
          b    = scatter();
          b.op = OP_TICK;
          play(b, 1'b0, tally);
        end
      end
    end

    // Wait for the last owed bytes, then watch for strays while the pipeline settles.
    drain_and_settle();
    if (pin_q.size() != 0) begin
      fail_count++;
      $display("ERROR: %0d pin bytes never arrived", pin_q.size());
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
